FILE: hdl/chs_pkg.sv
// Shared types and constants of the chained string hash set.
// No dependencies; imported by chs_ram's users and the top level.
package chs_pkg;

  localparam int unsigned MAX_BUCKETS_DEF      = 16;
  localparam int unsigned SLOTS_PER_BUCKET_DEF = 4;
  localparam int unsigned MAX_KEY_BYTES_DEF    = 8;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned KEY_IN_W     = 64;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned BUCKET_OUT_W = 4;
  localparam int unsigned CFG_W        = 5;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 5'd10;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

endpackage

FILE: hdl/chained_string_hash_set.sv
// Top level of the chained string hash set: sequencer, byte adder, remainder subtractor, slot probe.
// Depends on chs_pkg and chs_ram.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   op_i, key_bytes_i, key_length_i
//   out       output     out_valid_o/out_ready_i status_o, bucket_o
//   cfg       input      cfg_we_i                cfg_wdata_i (bucket count)
//
// One item at a time: after the input transfer the key bytes are summed one per cycle,
// the sum is reduced by a restoring remainder one bit per cycle, then the bucket's slots
// are read from the slot RAM one per cycle, and a final step updates the set and loads
// the result. The result and ready return together, so the block takes no new input
// while it is still working on the last one.
// Reset clears all slot valid bits at once and sets the bucket count to 10.
// A stalled result holds the block in its final step; the input waits until it is taken.
module chained_string_hash_set
  import chs_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS      = MAX_BUCKETS_DEF,
  parameter int unsigned SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
  parameter int unsigned MAX_KEY_BYTES    = MAX_KEY_BYTES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic [KEY_IN_W-1:0]     key_bytes_i,
  input  logic [LEN_W-1:0]        key_length_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [BUCKET_OUT_W-1:0] bucket_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned SLOT_COUNT = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int unsigned SW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned KEY_W      = 8 * MAX_KEY_BYTES;
  localparam int unsigned ENT_W      = KEY_W + LEN_W;
  localparam int unsigned SUM_W      = $clog2(255 * MAX_KEY_BYTES + 1);
  localparam int unsigned BC_W       = $clog2(SUM_W);
  localparam int unsigned BI_W       = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned PC_W       = $clog2(SLOTS_PER_BUCKET + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_DIV   = 5'b00100,
    S_PROBE = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  // control
  state_e                  state_q, state_d;
  logic [CFG_W-1:0]        bc_q, bc_d;
  logic [BI_W-1:0]         byte_idx_q, byte_idx_d;
  logic [BC_W-1:0]         bit_cnt_q, bit_cnt_d;
  logic [PC_W-1:0]         probe_cnt_q, probe_cnt_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic                    hit_q, hit_d;
  logic                    free_q, free_d;
  logic [SLOT_COUNT-1:0]   valid_q, valid_d;
  logic                    out_valid_q, out_valid_d;

  // payload
  op_e                     op_q, op_d;
  logic [KEY_W-1:0]        key_q, key_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [CFG_W-1:0]        div_q, div_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [CFG_W-1:0]        rem_q, rem_d;
  logic [SW-1:0]           cmp_ptr_q, cmp_ptr_d;
  logic [SW-1:0]           hit_ptr_q, hit_ptr_d;
  logic [SW-1:0]           free_ptr_q, free_ptr_d;
  status_e                 status_q, status_d;
  logic [BUCKET_OUT_W-1:0] bucket_q, bucket_d;

  // slot RAM
  logic                    ram_we;
  logic [SW-1:0]           ram_addr;
  logic [ENT_W-1:0]        ram_wdata;
  logic [ENT_W-1:0]        ram_rdata;

  logic [LEN_W-1:0]        len_sat;
  logic [CFG_W:0]          trial;
  logic [31:0]             slot_sum;
  logic [SW-1:0]           slot_addr;
  logic                    slot_match;

  chs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign len_sat = (32'(key_length_i) > MAX_KEY_BYTES) ? LEN_W'(MAX_KEY_BYTES) : key_length_i;

  // subtractor step of the restoring remainder
  assign trial = {rem_q, sum_q[SUM_W-1]};

  assign slot_sum   = 32'(rem_q) * 32'(SLOTS_PER_BUCKET) + 32'(probe_cnt_q);
  assign slot_addr  = slot_sum[SW-1:0];
  assign slot_match = (ram_rdata[ENT_W-1 -: LEN_W] == len_q) && (ram_rdata[KEY_W-1:0] == key_q);

  always_comb begin
    state_d     = state_q;
    bc_d        = bc_q;
    byte_idx_d  = byte_idx_q;
    bit_cnt_d   = bit_cnt_q;
    probe_cnt_d = probe_cnt_q;
    cmp_vld_d   = 1'b0;
    hit_d       = hit_q;
    free_d      = free_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    key_d       = key_q;
    len_d       = len_q;
    div_d       = div_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    cmp_ptr_d   = slot_addr;
    hit_ptr_d   = hit_ptr_q;
    free_ptr_d  = free_ptr_q;
    status_d    = status_q;
    bucket_d    = bucket_q;
    ram_we      = 1'b0;
    ram_addr    = slot_addr;
    ram_wdata   = {len_q, key_q};
    in_ready_o  = 1'b0;

    if (cfg_we_i) begin
      bc_d = cfg_wdata_i;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = op_e'(op_i);
          len_d = len_sat;
          for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            key_d[8*b +: 8] = (b < 32'(len_sat)) ? key_bytes_i[8*b +: 8] : 8'd0;
          end
          if (bc_q == '0) begin
            div_d = CFG_W'(1);
          end else if (32'(bc_q) > MAX_BUCKETS) begin
            div_d = CFG_W'(MAX_BUCKETS);
          end else begin
            div_d = bc_q;
          end
          sum_d      = '0;
          byte_idx_d = '0;
          state_d    = S_SUM;
        end
      end
      S_SUM: begin
        // masked bytes are zero, so every byte position may be added
        sum_d      = sum_q + SUM_W'(key_q[8*byte_idx_q +: 8]);
        byte_idx_d = byte_idx_q + 1'b1;
        if (byte_idx_q == BI_W'(MAX_KEY_BYTES - 1)) begin
          rem_d     = '0;
          bit_cnt_d = BC_W'(SUM_W - 1);
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = CFG_W'(trial - {1'b0, div_q});
        end else begin
          rem_d = CFG_W'(trial);
        end
        sum_d     = sum_q << 1;
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          probe_cnt_d = '0;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          state_d     = S_PROBE;
        end
      end
      S_PROBE: begin
        // read one slot per cycle, compare the slot read in the previous cycle
        cmp_vld_d   = (32'(probe_cnt_q) < SLOTS_PER_BUCKET);
        probe_cnt_d = probe_cnt_q + 1'b1;
        if (cmp_vld_q) begin
          if (valid_q[cmp_ptr_q]) begin
            if (!hit_q && slot_match) begin
              hit_d     = 1'b1;
              hit_ptr_d = cmp_ptr_q;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_ptr_d = cmp_ptr_q;
          end
        end
        if (32'(probe_cnt_q) == SLOTS_PER_BUCKET) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ram_addr = free_ptr_q;
        if (!out_valid_q || out_ready_i) begin
          case (op_q)
            OP_INSERT: begin
              if (hit_q) begin
                status_d = ST_PRESENT;
              end else if (!free_q) begin
                status_d = ST_FULL;
              end else begin
                status_d            = ST_INSERTED;
                ram_we              = 1'b1;
                valid_d[free_ptr_q] = 1'b1;
              end
            end
            OP_DELETE: begin
              if (hit_q) begin
                status_d           = ST_DELETED;
                valid_d[hit_ptr_q] = 1'b0;
              end else begin
                status_d = ST_NOT_FOUND;
              end
            end
            default: begin
              status_d = hit_q ? ST_FOUND : ST_NOT_FOUND;
            end
          endcase
          bucket_d    = BUCKET_OUT_W'(rem_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bc_q        <= BUCKET_COUNT_RESET;
      byte_idx_q  <= '0;
      bit_cnt_q   <= '0;
      probe_cnt_q <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bc_q        <= bc_d;
      byte_idx_q  <= byte_idx_d;
      bit_cnt_q   <= bit_cnt_d;
      probe_cnt_q <= probe_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    len_q      <= len_d;
    div_q      <= div_d;
    sum_q      <= sum_d;
    rem_q      <= rem_d;
    cmp_ptr_q  <= cmp_ptr_d;
    hit_ptr_q  <= hit_ptr_d;
    free_ptr_q <= free_ptr_d;
    status_q   <= status_d;
    bucket_q   <= bucket_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign bucket_o    = bucket_q;

endmodule

FILE: hdl/chs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the slot key and length entries.
module chs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/chained_string_hash_set_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for chained_string_hash_set: insert, search and delete of short keys.
// Depends on chs_pkg and the chained_string_hash_set RTL; holds its own shadow of the set.
module chained_string_hash_set_tb;
  import chs_pkg::*;

  localparam int unsigned SLOTS      = SLOTS_PER_BUCKET_DEF;
  localparam int unsigned BUCKETS    = MAX_BUCKETS_DEF;
  localparam int unsigned KEY_BYTES  = MAX_KEY_BYTES_DEF;
  localparam int unsigned SLOT_TOTAL = BUCKETS * SLOTS;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned PHASE_ITEMS  = 95;

  typedef struct {
    op_e                   op;
    logic [KEY_IN_W-1:0]   key;
    logic [LEN_W-1:0]      len;
  } request_t;

  typedef struct {
    status_e                 status;
    logic [BUCKET_OUT_W-1:0] bucket;
  } reply_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [OP_W-1:0]         op_i = '0;
  logic [KEY_IN_W-1:0]     key_bytes_i = '0;
  logic [LEN_W-1:0]        key_length_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [STATUS_W-1:0]     status_o;
  logic [BUCKET_OUT_W-1:0] bucket_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;

  // shadow copy of the set and its register
  logic                shadow_used [SLOT_TOTAL];
  logic [KEY_IN_W-1:0] shadow_key  [SLOT_TOTAL];
  logic [LEN_W-1:0]    shadow_len  [SLOT_TOTAL];
  logic [CFG_W-1:0]    shadow_bucket_count;

  request_t pending_requests[$];
  reply_t   expected_replies[$];

  logic [KEY_IN_W-1:0] key_pool [8];
  logic [LEN_W-1:0]    len_pool [8];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  logic        in_xfer_seen = 1'b0;

  chained_string_hash_set DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .key_bytes_i  (key_bytes_i),
    .key_length_i (key_length_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .bucket_o     (bucket_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one request to the shadow set and return the reply it must produce.
  task automatic apply_to_shadow_set(input logic [OP_W-1:0] op, input logic [KEY_IN_W-1:0] raw,
                                     input logic [LEN_W-1:0] raw_len, output reply_t rep);
    int unsigned len;
    int unsigned divisor;
    int unsigned sum;
    int unsigned bkt;
    int          hit;
    int          free_slot;
    logic [KEY_IN_W-1:0] key;
    len = (raw_len > KEY_BYTES) ? KEY_BYTES : raw_len;
    key = '0;
    sum = 0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (b < len) begin
        key[8*b +: 8] = raw[8*b +: 8];
        sum += raw[8*b +: 8];
      end
    end
    divisor = shadow_bucket_count;
    if (divisor == 0) divisor = 1;
    if (divisor > BUCKETS) divisor = BUCKETS;
    bkt = sum % divisor;
    hit = -1;
    free_slot = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (shadow_used[bkt*SLOTS + s]) begin
        if (hit < 0 && shadow_len[bkt*SLOTS + s] == len && shadow_key[bkt*SLOTS + s] == key)
          hit = bkt*SLOTS + s;
      end else if (free_slot < 0) begin
        free_slot = bkt*SLOTS + s;
      end
    end
    rep.bucket = BUCKET_OUT_W'(bkt);
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          rep.status = ST_PRESENT;
        end else if (free_slot < 0) begin
          rep.status = ST_FULL;
        end else begin
          shadow_used[free_slot] = 1'b1;
          shadow_key[free_slot]  = key;
          shadow_len[free_slot]  = LEN_W'(len);
          rep.status = ST_INSERTED;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          shadow_used[hit] = 1'b0;
          rep.status = ST_DELETED;
        end else begin
          rep.status = ST_NOT_FOUND;
        end
      end
      default: rep.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
    endcase
  endtask

  task automatic queue_request(input op_e op, input logic [KEY_IN_W-1:0] key,
                               input logic [LEN_W-1:0] len);
    request_t req;
    req.op  = op;
    req.key = key;
    req.len = len;
    pending_requests.push_back(req);
  endtask

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return OP_INSERT;
    if (r < 65) return OP_SEARCH;
    if (r < 95) return OP_DELETE;
    return OP_SPARE;
  endfunction

  // Mostly reuse pooled keys so inserts, hits and deletes interleave; sometimes add fresh keys.
  task automatic queue_random_request();
    int unsigned idx;
    int unsigned len;
    logic [KEY_IN_W-1:0] key;
    logic [KEY_IN_W-1:0] noise;
    idx = $urandom_range(7);
    if ($urandom_range(99) < 70) begin
      len = len_pool[idx];
      key = key_pool[idx];
      // garbage above the key length must not matter
      if ($urandom_range(99) < 30) begin
        noise = {$urandom, $urandom};
        for (int b = 0; b < KEY_BYTES; b++)
          if (b >= len) key[8*b +: 8] = noise[8*b +: 8];
      end
      if (len == KEY_BYTES && $urandom_range(3) == 0) len = $urandom_range(15, 9);
      queue_request(pick_op(), key, LEN_W'(len));
    end else begin
      // retire the evicted key so the set does not clog
      queue_request(OP_DELETE, key_pool[idx], len_pool[idx]);
      len = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
      key = {$urandom, $urandom};
      if ($urandom_range(3) == 0) key = key & 64'h0303_0303_0303_0303;
      key_pool[idx] = key;
      len_pool[idx] = LEN_W'(len);
      queue_request(pick_op(), key, LEN_W'(len));
    end
  endtask

  // Sender: present a new item once the previous one has transferred.
  always @(negedge clk_i) begin
    request_t req;
    if (!in_valid_i || in_xfer_seen) begin
      if (rst_ni && pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        req = pending_requests.pop_front();
        in_valid_i   <= 1'b1;
        op_i         <= req.op;
        key_bytes_i  <= req.key;
        key_length_i <= req.len;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_requested != holds_done) begin
      out_ready_i <= 1'b0;
      hold_left   <= LONG_HOLD;
      holds_done  <= holds_done + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      in_xfer_seen <= 1'b0;
    end else begin
      in_xfer_seen <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d bucket %0d",
                   $time, status_o, bucket_o);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status_o);
            mismatch_count++;
          end
          if (bucket_o !== want.bucket) begin
            $display("%0t: bucket mismatch: expected %0d, got %0d", $time, want.bucket, bucket_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        apply_to_shadow_set(op_i, key_bytes_i, key_length_i, got);
        expected_replies.push_back(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_for_idle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] value);
    wait_for_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    shadow_bucket_count = value;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_counts [12];
    phase_counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd10, 5'd3, 5'd16, 5'd12, 5'd2, 5'd5, 5'd9};
    shadow_bucket_count = BUCKET_COUNT_RESET;
    for (int i = 0; i < SLOT_TOTAL; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
      shadow_len[i]  = '0;
    end
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = {$urandom, $urandom};
      len_pool[i] = LEN_W'($urandom_range(8));
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    sender_idle_pct   = 11;
    receiver_idle_pct = 60;
    // directed: mostly bucket 0 under the reset count of ten
    queue_request(OP_INSERT, 64'h0, 4'd0);                   // empty key
    queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0); // empty key, stray bytes
    queue_request(OP_SEARCH, 64'h0, 4'd0);
    queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8); // widest key
    queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15); // saturates to eight
    queue_request(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9);
    queue_request(OP_INSERT, 64'hDEAD_BEEF_CAFE_F00A, 4'd1);
    queue_request(OP_SEARCH, 64'h0000_0000_0000_000A, 4'd1);
    queue_request(OP_INSERT, 64'h0000_0000_0000_0014, 4'd1); // bucket now full
    queue_request(OP_INSERT, 64'h0000_0000_0000_001E, 4'd1);
    queue_request(OP_SPARE,  64'h0000_0000_0000_0014, 4'd1);
    queue_request(OP_DELETE, 64'h1234_0000_0000_0014, 4'd1);
    queue_request(OP_DELETE, 64'h0000_0000_0000_0014, 4'd1);
    queue_request(OP_SEARCH, 64'h0000_0000_0000_0014, 4'd1);
    queue_request(OP_SPARE,  64'h0000_0000_0000_0014, 4'd1);
    queue_request(OP_INSERT, 64'h0000_0000_0000_001E, 4'd1); // reuses the freed slot
    queue_request(OP_SEARCH, 64'h0000_0000_0000_0A00, 4'd2); // same sum, other key
    queue_request(OP_DELETE, 64'h0000_0000_0000_0000, 4'd0);
    queue_request(OP_SEARCH, 64'h0000_0000_0000_0000, 4'd0);
    queue_request(OP_INSERT, 64'h0102_0304_0506_0708, 4'd8);
    queue_request(OP_INSERT, 64'h0102_0304_0506_0708, 4'd7); // length differs
    queue_request(OP_SEARCH, 64'h0002_0304_0506_0708, 4'd7);

    for (int p = 0; p < 12; p++) begin
      write_bucket_count(phase_counts[p]);
      if (p < 4) begin
        sender_idle_pct   = 11;
        receiver_idle_pct = 60;
      end else if (p < 8) begin
        sender_idle_pct   = 60;
        receiver_idle_pct = 11;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      // stall the output while the sender keeps offering
      if (p == 1 || p == 9) holds_requested++;
      // keys stored under the old count stay put; probe them under the new one
      queue_request(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      queue_request(OP_SEARCH, 64'h0000_0000_0000_001E, 4'd1);
      for (int n = 0; n < PHASE_ITEMS; n++) queue_random_request();
    end

    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
